// ===== design/bdhe_pkg.sv =====
// ----------------------------------------------------------------------------
// bdhe_pkg
// Shared types and constants for the button debounce and hold event block.
// ----------------------------------------------------------------------------
package bdhe_pkg;

  localparam int THR_W   = 16;
  localparam int CFG_IDX_W = 4;

  typedef logic [THR_W-1:0]     thr_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [2:0]           pressed_t;
  typedef logic [1:0]           btn_t;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_DOWN         = 3'd1,
    EV_RELEASE      = 3'd2,
    EV_HOLD         = 3'd3,
    EV_HOLD_RELEASE = 3'd4
  } ev_t;

  localparam cfg_idx_t CFG_DOWN_TICKS = CFG_IDX_W'(0);
  localparam cfg_idx_t CFG_HOLD_TICKS = CFG_IDX_W'(1);

  localparam thr_t DOWN_TICKS_RST = THR_W'(5);
  localparam thr_t HOLD_TICKS_RST = THR_W'(100);

endpackage

// ===== design/button_debounce_hold_events.sv =====
// ----------------------------------------------------------------------------
// button_debounce_hold_events
// Debounces push buttons and reports down, release, hold and hold-release
// events through a single pending event slot.
//
// Input channel (in_valid / in_stall): each transfer is either a sample tick
// (in_kind = tick) carrying the pushed bits in in_pressed, or a read that
// returns the pending event and clears it. Ticks give no result.
// Result channel (out_valid / out_stall): one transfer per read, with
// out_event_type and out_event_button.
// Configuration (cfg_valid / cfg_ready): index 0 down_ticks, 1 hold_ticks;
// cfg_ready is always high, other indexes are ignored.
// A read passes the stage register and then the result register.
// Throughput: one item per cycle; the single stage register feeds the
// counter and event logic, and the result register parts the two sides.
// The stage stalls only when it holds a read while a result waits stalled.
// Reset clears counters, the pending slot and both valid flags, and loads
// the threshold defaults 5 and 100.
// ----------------------------------------------------------------------------
module button_debounce_hold_events #(
  parameter int NUM_BUTTONS = 3,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bdhe_pkg::kind_t     in_kind,
  input  bdhe_pkg::pressed_t  in_pressed,
  output logic                out_valid,
  input  logic                out_stall,
  output bdhe_pkg::ev_t       out_event_type,
  output bdhe_pkg::btn_t      out_event_button,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  bdhe_pkg::cfg_idx_t  cfg_index,
  input  bdhe_pkg::thr_t      cfg_data
);
  import bdhe_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
  localparam int PW    = (NUM_BUTTONS > 3) ? NUM_BUTTONS : 3;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  thr_t     down_ticks_r, hold_ticks_r;
  cnt_t     cnt_r   [NUM_BUTTONS];
  cnt_t     cnt_nxt [NUM_BUTTONS];
  ev_t      pend_type_r, pend_type_nxt;
  btn_t     pend_btn_r, pend_btn_nxt;

  logic     stg_valid_r, stg_valid_nxt;
  kind_t    stg_kind_r;
  pressed_t stg_pressed_r;
  logic     stg_fire, in_xfer, out_load;
  logic     out_valid_r, out_valid_nxt;
  ev_t      out_type_r;
  btn_t     out_btn_r;
  logic [PW-1:0] pushed;

  assign cfg_ready = 1'b1;

  assign stg_fire = stg_valid_r &&
                    !((stg_kind_r == KIND_READ) && out_valid_r && out_stall);
  assign in_stall = stg_valid_r && !stg_fire;
  assign in_xfer  = in_valid && !in_stall;
  assign out_load = stg_fire && (stg_kind_r == KIND_READ);

  assign stg_valid_nxt = in_xfer ? 1'b1 : (stg_fire ? 1'b0 : stg_valid_r);
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  assign pushed = PW'(stg_pressed_r);

  // per-button counting, ascending order so higher buttons win the slot
  always_comb begin
    cnt_nxt       = cnt_r;
    pend_type_nxt = pend_type_r;
    pend_btn_nxt  = pend_btn_r;
    if (stg_fire) begin
      if (stg_kind_r == KIND_TICK) begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          if (pushed[b]) begin
            if (cnt_r[b] != '1) begin
              cnt_nxt[b] = cnt_r[b] + COUNT_WIDTH'(1);
              if (CMP_W'(cnt_r[b] + COUNT_WIDTH'(1)) == CMP_W'(hold_ticks_r)) begin
                pend_type_nxt = EV_HOLD;
                pend_btn_nxt  = 2'(b);
              end else if (CMP_W'(cnt_r[b] + COUNT_WIDTH'(1)) == CMP_W'(down_ticks_r)) begin
                pend_type_nxt = EV_DOWN;
                pend_btn_nxt  = 2'(b);
              end
            end
          end else begin
            if (CMP_W'(cnt_r[b]) > CMP_W'(hold_ticks_r)) begin
              pend_type_nxt = EV_HOLD_RELEASE;
              pend_btn_nxt  = 2'(b);
            end else if (CMP_W'(cnt_r[b]) > CMP_W'(down_ticks_r)) begin
              pend_type_nxt = EV_RELEASE;
              pend_btn_nxt  = 2'(b);
            end
            cnt_nxt[b] = '0;
          end
        end
      end else begin
        pend_type_nxt = EV_NONE;
        pend_btn_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_ticks_r <= DOWN_TICKS_RST;
      hold_ticks_r <= HOLD_TICKS_RST;
      for (int b = 0; b < NUM_BUTTONS; b++) cnt_r[b] <= '0;
      pend_type_r  <= EV_NONE;
      pend_btn_r   <= '0;
      stg_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DOWN_TICKS) down_ticks_r <= cfg_data;
        if (cfg_index == CFG_HOLD_TICKS) hold_ticks_r <= cfg_data;
      end
      cnt_r       <= cnt_nxt;
      pend_type_r <= pend_type_nxt;
      pend_btn_r  <= pend_btn_nxt;
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_kind_r    <= in_kind;
      stg_pressed_r <= in_pressed;
    end
    if (out_load) begin
      out_type_r <= pend_type_r;
      out_btn_r  <= (pend_type_r == EV_NONE) ? '0 : pend_btn_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_type   = out_type_r;
  assign out_event_button = out_btn_r;

endmodule

// ===== design/bdhe_checker.sv =====
// ----------------------------------------------------------------------------
// bdhe_checker
// Port-level checks for button_debounce_hold_events, bound to the top level.
// ----------------------------------------------------------------------------
module bdhe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input bdhe_pkg::kind_t    in_kind,
  input logic               out_valid,
  input logic               out_stall,
  input bdhe_pkg::ev_t      out_event_type,
  input bdhe_pkg::btn_t     out_event_button
);
  import bdhe_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_type)
                               && $stable(out_event_button))
    else $error("stalled result changed");

  // an empty event carries button zero
  a_none_btn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_type == EV_NONE) |-> out_event_button == '0)
    else $error("empty event with nonzero button");

  // a read transfer reaches the output when nothing waits
  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_kind == KIND_READ) && !out_valid) ##1 !out_valid
      |=> out_valid)
    else $error("read result missing");

  // nothing valid right after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind button_debounce_hold_events bdhe_checker u_bdhe_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_kind          (in_kind),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_event_type   (out_event_type),
  .out_event_button (out_event_button)
);

// ===== test/tb_button_debounce_hold_events.sv =====
// ----------------------------------------------------------------------------
// tb_button_debounce_hold_events
// Self-checking bench for the button debouncer with hold events. A local
// model of the press counters, thresholds and pending event slot predicts
// the result of every read; each result transfer is compared field by field
// with the oldest prediction. Directed tests cover thresholds, priority,
// overwrite, ignored register indexes and long presses, followed by
// random press patterns under several threshold settings.
// ----------------------------------------------------------------------------
module tb_button_debounce_hold_events;
  import bdhe_pkg::*;

  localparam int        CNT_W         = 16;
  localparam int        BUTTONS       = 3;
  localparam cfg_idx_t  CFG_IDX_SPARE = cfg_idx_t'(2);
  localparam cfg_idx_t  CFG_IDX_TOP   = cfg_idx_t'(15);
  localparam int        SETTLE_CYCLES = 4;
  localparam int        GAP_PCT       = 33;

  typedef struct packed {
    ev_t  ev;
    btn_t btn;
  } event_rec_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  kind_t      in_kind;
  pressed_t   in_pressed;
  logic       out_valid;
  logic       out_stall = 1'b0;
  ev_t        out_event_type;
  btn_t       out_event_button;
  logic       cfg_valid;
  logic       cfg_ready;
  cfg_idx_t   cfg_index;
  thr_t       cfg_data;

  // model state
  thr_t             down_thr;
  thr_t             hold_thr;
  logic [CNT_W-1:0] press_cnt [BUTTONS];
  ev_t              pend_ev;
  btn_t             pend_btn;
  event_rec_t       event_q[$];

  bit gaps_on = 1'b1;
  int errors = 0;
  int n_ticks = 0;
  int n_reads = 0;
  int n_writes = 0;
  int n_checked = 0;
  int n_settings = 0;

  button_debounce_hold_events dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_pressed       (in_pressed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_type   (out_event_type),
    .out_event_button (out_event_button),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  // ---------------- model ----------------

  task automatic model_reset();
    down_thr = DOWN_TICKS_RST;
    hold_thr = HOLD_TICKS_RST;
    for (int b = 0; b < BUTTONS; b++) press_cnt[b] = '0;
    pend_ev  = EV_NONE;
    pend_btn = '0;
  endtask

  task automatic advance_counters(pressed_t pressed);
    logic [CNT_W-1:0] c;
    for (int b = 0; b < BUTTONS; b++) begin
      if (pressed[b]) begin
        if (press_cnt[b] != '1) begin
          c = press_cnt[b] + 1'b1;
          press_cnt[b] = c;
          if (c == hold_thr) begin
            pend_ev  = EV_HOLD;
            pend_btn = btn_t'(b);
          end else if (c == down_thr) begin
            pend_ev  = EV_DOWN;
            pend_btn = btn_t'(b);
          end
        end
      end else begin
        c = press_cnt[b];
        if (c > hold_thr) begin
          pend_ev  = EV_HOLD_RELEASE;
          pend_btn = btn_t'(b);
        end else if (c > down_thr) begin
          pend_ev  = EV_RELEASE;
          pend_btn = btn_t'(b);
        end
        press_cnt[b] = '0;
      end
    end
  endtask

  task automatic take_pending();
    event_rec_t rec;
    rec.ev  = pend_ev;
    rec.btn = (pend_ev == EV_NONE) ? btn_t'(0) : pend_btn;
    event_q.push_back(rec);
    pend_ev  = EV_NONE;
    pend_btn = '0;
  endtask

  // ---------------- drivers ----------------

  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(0, 99) < GAP_PCT);
  end

  task automatic send_item(kind_t kind, pressed_t pressed);
    @(negedge clk);
    while (gaps_on && ($urandom_range(0, 99) < GAP_PCT)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_pressed <= pressed;
    do @(posedge clk); while (in_stall);
    if (kind == KIND_TICK) begin
      advance_counters(pressed);
      n_ticks++;
    end else begin
      take_pending();
      n_reads++;
    end
  endtask

  task automatic tick(pressed_t pressed, int count = 1);
    repeat (count) send_item(KIND_TICK, pressed);
  endtask

  task automatic read_event();
    send_item(KIND_READ, pressed_t'($urandom_range(0, 7)));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (event_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, thr_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DOWN_TICKS: down_thr = data;
      CFG_HOLD_TICKS: hold_thr = data;
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_thresholds(thr_t down, thr_t hold);
    drain();
    write_reg(CFG_DOWN_TICKS, down);
    write_reg(CFG_HOLD_TICKS, hold);
    n_settings++;
  endtask

  // ---------------- checker ----------------

  always @(posedge clk) begin
    event_rec_t exp_rec;
    if (rst_n && out_valid && !out_stall) begin
      if (event_q.size() == 0) begin
        $error("unexpected result transfer: event_type %0d event_button %0d",
               out_event_type, out_event_button);
        errors++;
      end else begin
        exp_rec = event_q.pop_front();
        n_checked++;
        if (out_event_type !== exp_rec.ev) begin
          $error("event_type: expected %0d, got %0d", exp_rec.ev, out_event_type);
          errors++;
        end
        if (out_event_button !== exp_rec.btn) begin
          $error("event_button: expected %0d, got %0d", exp_rec.btn, out_event_button);
          errors++;
        end
      end
    end
  end

  // ---------------- tests ----------------

  task automatic test_empty_read();
    read_event();
  endtask

  task automatic test_down_release();
    set_thresholds(thr_t'(2), thr_t'(4));
    tick(3'b001, 2);
    read_event();
    tick(3'b010, 3);
    tick(3'b000);
    read_event();
  endtask

  task automatic test_hold_events();
    set_thresholds(thr_t'(2), thr_t'(4));
    tick(3'b100, 4);
    read_event();
    tick(3'b000);
    read_event();
    tick(3'b100, 5);
    tick(3'b000);
    read_event();
  endtask

  task automatic test_equal_thresholds_overwrite();
    set_thresholds(thr_t'(3), thr_t'(3));
    tick(3'b111, 3);
    read_event();
    tick(3'b011);
    tick(3'b000);
    read_event();
  endtask

  task automatic test_zero_down();
    set_thresholds(thr_t'(0), thr_t'(2));
    tick(3'b001);
    tick(3'b000);
    read_event();
    tick(3'b001, 2);
    read_event();
  endtask

  task automatic test_hold_below_down();
    set_thresholds(thr_t'(5), thr_t'(2));
    tick(3'b010, 5);
    read_event();
    tick(3'b000);
    read_event();
  endtask

  task automatic test_ignored_index();
    drain();
    write_reg(CFG_IDX_SPARE, 16'hffff);
    write_reg(CFG_IDX_TOP, 16'h0000);
    tick(3'b100, 2);
    read_event();
  endtask

  task automatic test_long_press();
    set_thresholds(thr_t'(16), thr_t'(32));
    gaps_on = 1'b0;
    for (int i = 0; i < 36; i++) begin
      send_item(KIND_TICK, 3'b111);
      if (i % 8 == 0 || i >= 30) read_event();
    end
    tick(3'b000);
    read_event();
    read_event();
    drain();
    gaps_on = 1'b1;
  endtask

  task automatic run_traffic(thr_t down, thr_t hold, int toggle_pct, int n_items);
    pressed_t held;
    held = '0;
    set_thresholds(down, hold);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 25) begin
        read_event();
      end else if ($urandom_range(0, 99) < 8) begin
        tick(pressed_t'($urandom_range(0, 7)));
      end else begin
        for (int b = 0; b < BUTTONS; b++)
          if ($urandom_range(0, 99) < toggle_pct) held[b] = ~held[b];
        tick(held);
      end
    end
  endtask

  task automatic test_random();
    thr_t d;
    run_traffic(DOWN_TICKS_RST, HOLD_TICKS_RST, 2, 50);
    run_traffic(thr_t'(1), thr_t'(2), 20, 60);
    run_traffic(thr_t'(3), thr_t'(3), 15, 60);
    run_traffic(thr_t'(0), thr_t'(1), 25, 50);
    run_traffic(thr_t'(6), thr_t'(3), 10, 60);
    d = thr_t'($urandom_range(1, 8));
    run_traffic(d, d + thr_t'($urandom_range(1, 16)), 8, 50);
    gaps_on = 1'b0;
    d = thr_t'($urandom_range(1, 8));
    run_traffic(d, d + thr_t'($urandom_range(1, 16)), 12, 50);
    drain();
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_kind    = KIND_TICK;
    in_pressed = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    model_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_read();
    test_down_release();
    test_hold_events();
    test_equal_thresholds_overwrite();
    test_zero_down();
    test_hold_below_down();
    test_ignored_index();
    test_long_press();
    test_random();
    drain();

    $display("covered %0d sample ticks and %0d reads over %0d threshold settings",
             n_ticks, n_reads, n_settings);
    $display("%0d register writes, %0d event results compared", n_writes, n_checked);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== button_debounce_hold_events.f =====
design/bdhe_pkg.sv
design/button_debounce_hold_events.sv
design/bdhe_checker.sv
test/tb_button_debounce_hold_events.sv
